/* sv/window_stack_hit_test_unit_defines.svh */
// ----------------------------------------------------------------------------
// window_stack_hit_test_unit_defines.svh
// Assertion macros for the window stack hit test unit.
// ----------------------------------------------------------------------------
`ifndef WINDOW_STACK_HIT_TEST_UNIT_DEFINES_SVH
`define WINDOW_STACK_HIT_TEST_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during rst.
`define WSHT_ASSERT_IMPL(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("window stack hit test check failed");
// Next-cycle implication, sampled on clk, off during rst.
`define WSHT_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("window stack hit test check failed");
`else
`define WSHT_ASSERT_IMPL(label, cond, prop)
`define WSHT_ASSERT_NEXT(label, cond, prop)
`endif

`endif

/* sv/wsht_pkg.sv */
// ----------------------------------------------------------------------------
// wsht_pkg
// Types and fixed constants of the window stack hit test unit.
// ----------------------------------------------------------------------------
package wsht_pkg;

  localparam int FIELD_BITS = 12;  // coordinate port width
  localparam int ID_BITS    = 5;   // window number port width

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_CLICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_PLACE
  } state_t;

endpackage

/* sv/wsht_ram.sv */
// ----------------------------------------------------------------------------
// wsht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wsht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/window_stack_hit_test_unit.sv */
// ----------------------------------------------------------------------------
// window_stack_hit_test_unit
// Z-ordered window stack: loads push a window on top, clicks find the topmost
// window under the point, report its number and bring it to the top.
// ----------------------------------------------------------------------------
// Load: written at accept, no result; busy stays low, next item next cycle.
// Click that hits: busy through scan (top down to the hit), shift (entries above
//   slide down one place) and place (hit window to the top); done strobes after.
// Click that misses: busy while every held window is scanned, then done strobes;
//   on an empty stack done follows in the next cycle with busy low.
// Scan and shift share the single RAM port pair. rst (sync) empties the stack.
// ----------------------------------------------------------------------------
`include "window_stack_hit_test_unit_defines.svh"

module window_stack_hit_test_unit #(
  parameter int MAX_WINDOWS = 16,
  parameter int COORD_BITS  = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             func,
  input  logic [wsht_pkg::FIELD_BITS-1:0]  pos_x,
  input  logic [wsht_pkg::FIELD_BITS-1:0]  pos_y,
  input  logic [wsht_pkg::FIELD_BITS-1:0]  right_x,
  input  logic [wsht_pkg::FIELD_BITS-1:0]  top_y,
  output logic                             done,
  output logic                             hit,
  output logic [wsht_pkg::ID_BITS-1:0]     window_id
);

  import wsht_pkg::*;

  // Stack index, window count and window number widths.
  localparam int IDX_BITS = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CNT_BITS = $clog2(MAX_WINDOWS + 1);
  localparam int NUM_BITS = CNT_BITS;

  // Entry layout, top down: {left, bottom, right, top, number}.
  localparam int TOP_LSB   = NUM_BITS;
  localparam int RIGHT_LSB = TOP_LSB + COORD_BITS;
  localparam int BOT_LSB   = RIGHT_LSB + COORD_BITS;
  localparam int LEFT_LSB  = BOT_LSB + COORD_BITS;
  localparam int ENT_BITS  = LEFT_LSB + COORD_BITS;

  // Sequencer and control
  state_t state, state_next;
  logic   accept;

  logic [CNT_BITS-1:0]   count;     // windows held; entry count-1 is the top
  logic [CNT_BITS-1:0]   n;         // count frozen for the current click
  logic [COORD_BITS-1:0] px, py;    // click point

  // Scan: ptr is the address being read, chk_* tags the data coming back.
  logic [IDX_BITS-1:0]   ptr;
  logic                  chk_valid;
  logic [IDX_BITS-1:0]   chk_idx;

  // Move to front: entries above the hit slide down one place.
  logic [ENT_BITS-1:0]   found;
  logic [CNT_BITS-1:0]   sh_rd;
  logic                  mv_valid;
  logic [IDX_BITS-1:0]   mv_dst;

  // RAM ports
  logic                  wr_en, rd_en;
  logic [IDX_BITS-1:0]   wr_addr, rd_addr;
  logic [ENT_BITS-1:0]   wr_data, rd_data;

  // Fields of the entry read back, and the containment test (edges included)
  logic [COORD_BITS-1:0] ent_left, ent_bot, ent_right, ent_top;
  logic                  inside_win;
  logic                  hit_now;
  logic                  full;

  assign ent_left  = rd_data[LEFT_LSB  +: COORD_BITS];
  assign ent_bot   = rd_data[BOT_LSB   +: COORD_BITS];
  assign ent_right = rd_data[RIGHT_LSB +: COORD_BITS];
  assign ent_top   = rd_data[TOP_LSB   +: COORD_BITS];

  assign inside_win = (px >= ent_left) && (px <= ent_right) &&
                      (py >= ent_bot)  && (py <= ent_top);
  assign hit_now    = chk_valid && inside_win;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CNT_BITS'(MAX_WINDOWS));

  wsht_ram #(
    .WIDTH (ENT_BITS),
    .DEPTH (MAX_WINDOWS)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and RAM control
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    case (state)
      ST_IDLE: begin
        if (accept && (func == FUNC_LOAD) && !full) begin
          // Push the new window straight into the slot above the top.
          wr_en   = 1'b1;
          wr_addr = IDX_BITS'(count);
          wr_data = {COORD_BITS'(pos_x), COORD_BITS'(pos_y),
                     COORD_BITS'(right_x), COORD_BITS'(top_y),
                     NUM_BITS'(count + 1'b1)};
        end
        if (accept && (func == FUNC_CLICK) && (count != '0)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // One read issued per cycle, top down; each compare checks the read of the cycle before.
        rd_en   = 1'b1;
        rd_addr = ptr;
        if (hit_now) begin
          state_next = ST_SHIFT;
        end else if (chk_valid && (chk_idx == '0)) begin
          state_next = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        // Read entry k+1 while writing entry k from the previous read.
        if (sh_rd < n) begin
          rd_en   = 1'b1;
          rd_addr = sh_rd[IDX_BITS-1:0];
        end else begin
          state_next = ST_PLACE;
        end
        if (mv_valid) begin
          wr_en   = 1'b1;
          wr_addr = mv_dst;
          wr_data = rd_data;
        end
      end
      ST_PLACE: begin
        wr_en      = 1'b1;
        wr_addr    = IDX_BITS'(n - 1'b1);
        wr_data    = found;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      done      <= 1'b0;
      chk_valid <= 1'b0;
      mv_valid  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          chk_valid <= 1'b0;
          mv_valid  <= 1'b0;
          if (accept) begin
            px  <= COORD_BITS'(pos_x);
            py  <= COORD_BITS'(pos_y);
            n   <= count;
            ptr <= IDX_BITS'(count - 1'b1);
            if ((func == FUNC_LOAD) && !full) begin
              count <= count + 1'b1;
            end
            if ((func == FUNC_CLICK) && (count == '0)) begin
              // empty stack: immediate miss
              done      <= 1'b1;
              hit       <= 1'b0;
              window_id <= '0;
            end
          end
        end
        ST_SCAN: begin
          chk_valid <= 1'b1;
          chk_idx   <= ptr;
          if (ptr != '0) begin
            ptr <= ptr - 1'b1;
          end
          if (hit_now) begin
            found    <= rd_data;
            sh_rd    <= CNT_BITS'(chk_idx) + 1'b1;
            mv_valid <= 1'b0;
          end else if (chk_valid && (chk_idx == '0)) begin
            done      <= 1'b1;
            hit       <= 1'b0;
            window_id <= '0;
          end
        end
        ST_SHIFT: begin
          if (sh_rd < n) begin
            mv_valid <= 1'b1;
            mv_dst   <= IDX_BITS'(sh_rd - 1'b1);
            sh_rd    <= sh_rd + 1'b1;
          end else begin
            mv_valid <= 1'b0;
          end
        end
        ST_PLACE: begin
          done      <= 1'b1;
          hit       <= 1'b1;
          window_id <= ID_BITS'(found[NUM_BITS-1:0]);
        end
        default: begin
          done <= 1'b0;
        end
      endcase
    end
  end

  // Results only appear once the sequencer is back at rest.
  `WSHT_ASSERT_IMPL(a_done_idle, done, !busy)
  // A load on a full stack leaves the count alone.
  `WSHT_ASSERT_NEXT(a_full_drop, accept && (func == FUNC_LOAD) && full, $stable(count))
  // A click on a non-empty stack always starts a scan.
  `WSHT_ASSERT_NEXT(a_click_scan, accept && (func == FUNC_CLICK) && (count != '0), busy)
  // The slide never reads past the frozen top.
  `WSHT_ASSERT_IMPL(a_shift_bound, state == ST_SHIFT, sh_rd <= n)
  // The count never exceeds capacity.
  `WSHT_ASSERT_IMPL(a_count_cap, !busy, count <= CNT_BITS'(MAX_WINDOWS))

endmodule
